// ----- hw/rtl/mips_subset_execute_unit_top_macros.svh -----
// Assertion macros shared by the execute unit RTL.
// Needs clk and rst in scope at the point of use; empty when SYNTH is set.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_TOP_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define MSEU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MSEU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MSEU_ASSERT_IMP(lbl, ante, cons, msg)
`define MSEU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/mseu_pkg.sv -----
// Shared constants, codes and the decoded instruction type of the execute unit.
// No dependencies.
`default_nettype none

package mseu_pkg;

  localparam int DATA_WORDS = 4096;
  localparam int MAX_INST   = 1024;
  localparam int REG_COUNT  = 32;

  localparam int REG_AW  = $clog2(REG_COUNT);
  localparam int DMEM_AW = $clog2(DATA_WORDS);
  localparam int IC_W    = 11;   // inst_count register
  localparam int WA_W    = 29;   // word address of a non-negative byte address
  localparam int IDX_W   = 5;    // register index fields
  localparam int PC_W    = 10;

  localparam int S_TDATA_W = 96;
  localparam int S_TUSER_W = 8;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_ADDI = 4'd3,
    OP_BNE  = 4'd4,
    OP_BEQ  = 4'd5,
    OP_SLT  = 4'd6,
    OP_LW   = 4'd7,
    OP_SW   = 4'd8,
    OP_J    = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LABEL  = 2'd1,
    ERR_ACCESS = 2'd2,
    ERR_ALIGN  = 2'd3
  } err_t;

  // one instruction after classification; port A and port B are the two
  // register reads that the instruction needs
  typedef struct packed {
    op_t               op;
    logic [REG_AW-1:0] ra;
    logic              ra_ok;
    logic [REG_AW-1:0] rb;
    logic              rb_ok;
    logic [REG_AW-1:0] rd;
    logic              rd_ok;
    logic              wr_alu;
    logic              is_load;
    logic              is_store;
    logic [31:0]       imm;
    logic [31:0]       base_imm;
    logic              base_is_imm;
    logic [PC_W-1:0]   target;
    logic              target_known;
  } dec_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mseu_ram.sv -----
// Generic single-write RAM with one registered read port (old data on collision).
// No dependencies.
`default_nettype none

module mseu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mseu_front.sv -----
// Front end: accepts instruction requests and classifies them into dec_t.
// Depends on mseu_pkg.
`default_nettype none

module mseu_front
  import mseu_pkg::*;
(
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
  input  wire logic                 full,
  input  wire logic                 clearing,
  output logic                      push,
  output dec_t                      push_ent
);

  logic [IDX_W-1:0] reg_d, reg_s, reg_t, ra_idx, rb_idx;
  op_t              op;

  assign reg_d = s_axis_tdata[4:0];
  assign reg_s = s_axis_tdata[9:5];
  assign reg_t = s_axis_tdata[14:10];
  assign op    = op_t'(s_axis_tuser[3:0]);

  assign s_axis_tready = !full && !clearing;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ra_idx = reg_s;
    rb_idx = reg_t;
    push_ent.wr_alu   = 1'b0;
    push_ent.is_load  = 1'b0;
    push_ent.is_store = 1'b0;
    unique case (op) inside
      OP_BNE, OP_BEQ: begin
        ra_idx = reg_d;
        rb_idx = reg_s;
      end
      OP_SW: begin
        ra_idx = reg_d;
        push_ent.is_store = 1'b1;
      end
      OP_LW: begin
        push_ent.is_load = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_ADDI, OP_SLT: begin
        push_ent.wr_alu = 1'b1;
      end
      default: begin
      end
    endcase
    push_ent.op           = op;
    push_ent.ra           = ra_idx[REG_AW-1:0];
    push_ent.ra_ok        = 32'(ra_idx) < REG_COUNT;
    push_ent.rb           = rb_idx[REG_AW-1:0];
    push_ent.rb_ok        = 32'(rb_idx) < REG_COUNT;
    push_ent.rd           = reg_d[REG_AW-1:0];
    push_ent.rd_ok        = 32'(reg_d) < REG_COUNT;
    push_ent.imm          = s_axis_tdata[46:15];
    push_ent.base_imm     = s_axis_tdata[78:47];
    push_ent.base_is_imm  = s_axis_tuser[4];
    push_ent.target       = s_axis_tdata[88:79];
    push_ent.target_known = s_axis_tuser[5];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mseu_queue.sv -----
// Short FIFO of classified instructions between the front and back ends.
// Depends on mseu_pkg and the assertion macro header.
`default_nettype none
`include "mips_subset_execute_unit_top_macros.svh"

module mseu_queue
  import mseu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire dec_t push_ent,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output dec_t      head
);

  dec_t                ent [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MSEU_ASSERT_IMP(a_no_push_full, push, !full, "request pushed into a full queue")
  `MSEU_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "pop from an empty queue")
  `MSEU_ASSERT_NXT(a_count_up, push && !pop, count == $past(count) + 1'b1,
                   "queue count did not advance on push")

endmodule

`default_nettype wire

// ----- hw/rtl/mseu_back.sv -----
// Back end: register read, execute/address check, result register and write-back.
// Depends on mseu_pkg, mseu_ram and the assertion macro header.
`default_nettype none
`include "mips_subset_execute_unit_top_macros.svh"

module mseu_back
  import mseu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 head_valid,
  input  wire dec_t                 head,
  output logic                      pop,
  output logic                      clearing,
  input  wire logic                 cfg_we,
  input  wire logic [IC_W-1:0]      cfg_wdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  output logic [M_TUSER_W-1:0]      m_axis_tuser
);

  // configuration
  logic [IC_W-1:0] ic, ic_next;
  logic [WA_W-1:0] hi_lim;

  // execute stage
  logic       x_valid;
  dec_t       x;
  logic       a_vld_q, b_vld_q;
  logic [31:0] rf_qa, rf_qb;

  // write-back / result stage
  logic              w_valid, w_we, w_is_load;
  logic [REG_AW-1:0] w_dest;
  logic [31:0]       w_alu, w_wdata;
  logic              w_pcw, w_flag, w_taken;
  logic [PC_W-1:0]   w_npc;
  err_t              w_err;

  // write recorded at the last read edge, missed by the read-first RAM
  logic              byp_we;
  logic [REG_AW-1:0] byp_addr;
  logic [31:0]       byp_data;

  logic                  rf_vld [REG_COUNT];
  logic                  adv, fire, rf_we;
  logic [DMEM_AW-1:0]    clr_idx;
  logic [31:0]           opa, opb, res, base, sum, dm_q;
  logic [WA_W-1:0]       wa;
  err_t                  mem_err, err;
  logic                  pcw, flag, taken, we_next, ld_go, st_go;
  logic [PC_W-1:0]       npc;
  logic [DMEM_AW-1:0]    dm_idx, dm_waddr;
  logic                  dm_we;
  logic [31:0]           dm_wdata;

  assign adv  = !w_valid || m_axis_tready;
  assign fire = w_valid && m_axis_tready;
  assign pop  = adv && head_valid && !clearing;

  assign w_wdata = w_is_load ? dm_q : w_alu;
  assign rf_we   = fire && w_we;

  // register file: two copies give two read ports
  mseu_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(w_dest), .wdata(w_wdata),
    .re(adv), .raddr(head.ra), .rdata(rf_qa)
  );
  mseu_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(w_dest), .wdata(w_wdata),
    .re(adv), .raddr(head.rb), .rdata(rf_qb)
  );

  assign dm_we    = clearing || (adv && st_go);
  assign dm_waddr = clearing ? clr_idx : dm_idx;
  assign dm_wdata = clearing ? '0 : opa;

  mseu_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(adv && ld_go), .raddr(dm_idx), .rdata(dm_q)
  );

  // operand select: pending result, then recorded write, then stored value
  always_comb begin
    opa = '0;
    if (x.ra_ok) begin
      if (w_valid && w_we && w_dest == x.ra) begin
        opa = w_wdata;
      end else if (byp_we && byp_addr == x.ra) begin
        opa = byp_data;
      end else if (a_vld_q) begin
        opa = rf_qa;
      end
    end
    opb = '0;
    if (x.rb_ok) begin
      if (w_valid && w_we && w_dest == x.rb) begin
        opb = w_wdata;
      end else if (byp_we && byp_addr == x.rb) begin
        opb = byp_data;
      end else if (b_vld_q) begin
        opb = rf_qb;
      end
    end
  end

  // load/store address and checks
  always_comb begin
    base   = x.base_is_imm ? x.base_imm : opb;
    sum    = x.imm + base;
    wa     = sum[30:2];
    dm_idx = DMEM_AW'(wa) - DMEM_AW'(ic);
    if (sum[31] || wa < WA_W'(ic) || wa >= hi_lim) begin
      mem_err = ERR_ACCESS;
    end else if (sum[1:0] != 2'b00) begin
      mem_err = ERR_ALIGN;
    end else begin
      mem_err = ERR_NONE;
    end
  end

  always_comb begin
    res   = '0;
    err   = ERR_NONE;
    pcw   = 1'b0;
    npc   = '0;
    flag  = 1'b0;
    taken = 1'b0;
    unique case (x.op) inside
      OP_ADD:  res = opa + opb;
      OP_SUB:  res = opa - opb;
      OP_MUL:  res = opa * opb;
      OP_ADDI: res = opa + x.imm;
      OP_SLT:  res = {31'b0, $signed(opa) < $signed(opb)};
      OP_BNE, OP_BEQ: begin
        if (!x.target_known) begin
          err = ERR_LABEL;
        end else begin
          flag  = 1'b1;
          taken = (x.op == OP_BEQ) ? (opa == opb) : (opa != opb);
          pcw   = taken;
          npc   = taken ? x.target : '0;
        end
      end
      OP_LW, OP_SW: err = mem_err;
      OP_J: begin
        pcw = 1'b1;
        npc = x.target_known ? x.target : '0;
      end
      default: begin
      end
    endcase
    ld_go   = x_valid && x.is_load && mem_err == ERR_NONE;
    st_go   = x_valid && x.is_store && mem_err == ERR_NONE;
    we_next = x_valid && x.rd_ok && (x.wr_alu || ld_go);
  end

  always_comb begin
    ic_next = (32'(cfg_wdata) > MAX_INST) ? IC_W'(MAX_INST) : cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ic      <= '0;
      hi_lim  <= WA_W'(DATA_WORDS);
      x_valid <= 1'b0;
      w_valid <= 1'b0;
      byp_we  <= 1'b0;
      clearing <= 1'b1;
      clr_idx  <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_vld[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        ic     <= ic_next;
        hi_lim <= WA_W'(ic_next) + WA_W'(DATA_WORDS);
      end
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == DMEM_AW'(DATA_WORDS-1)) begin
          clearing <= 1'b0;
        end
      end
      if (rf_we) begin
        rf_vld[w_dest] <= 1'b1;
      end
      if (adv) begin
        x_valid <= pop;
        w_valid <= x_valid;
        w_we    <= we_next;
        byp_we  <= rf_we;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      x         <= head;
      a_vld_q   <= rf_vld[head.ra];
      b_vld_q   <= rf_vld[head.rb];
      byp_addr  <= w_dest;
      byp_data  <= w_wdata;
      w_dest    <= x.rd;
      w_is_load <= x.is_load;
      w_alu     <= res;
      w_pcw     <= pcw;
      w_npc     <= npc;
      w_flag    <= flag;
      w_taken   <= taken;
      w_err     <= err;
    end
  end

  assign m_axis_tvalid = w_valid;
  assign m_axis_tdata  = {3'b0, w_err, w_taken, w_npc};
  assign m_axis_tuser  = {6'b0, w_flag, w_pcw};

  `MSEU_ASSERT_IMP(a_no_result_clear, clearing, !m_axis_tvalid,
                   "result presented during the clearing pass")
  `MSEU_ASSERT_IMP(a_clear_end, $fell(clearing),
                   $past(clr_idx) == DMEM_AW'(DATA_WORDS-1),
                   "clearing pass ended early")

endmodule

`default_nettype wire

// ----- hw/rtl/mips_subset_execute_unit_top.sv -----
// Top level of the MIPS subset execute unit: front end, queue and back end.
// Depends on mseu_pkg, mseu_front, mseu_queue, mseu_back (and mseu_ram below it).
//
//   channel   direction  payload
//   s_axis    in         one decoded instruction request
//   m_axis    out        one result per request (pc/branch/error)
//   cfg       in         inst_count write, no read-back
//
// Cycles: one request per cycle sustained while m_axis_tready is high; each
// result passes queue head -> register read/execute -> result register.
// The execute stage with forwarding from the result register and from the
// last register-file write sets the one-per-cycle rate.
// Reset: a clearing pass zeroes all DATA_WORDS (4096) data memory words with
// s_axis_tready low; register file entries read as zero until written.
// Stalls: the result register holds while m_axis_tready is low; the 4-entry
// queue keeps the front accepting until it fills.
`default_nettype none

module mips_subset_execute_unit_top
  import mseu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request in
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata from bit 0: reg_d[4:0], reg_s[9:5], reg_t[14:10], imm[46:15],
  // base_imm[78:47], target[88:79], zero fill
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser from bit 0: operation[3:0], base_is_imm[4], target_known[5], zero fill
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
  // result out
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata from bit 0: new_pc[9:0], branch_taken[10], error_code[12:11], zero fill
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // tuser from bit 0: pc_write[0], branch_flag_write[1], zero fill
  output logic [M_TUSER_W-1:0]      m_axis_tuser,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [IC_W-1:0]      cfg_wdata
);

  logic full, clearing, push, pop, head_valid;
  dec_t push_ent, head;

  // classify requests; hold off while the queue is full or memory clears
  mseu_front u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .full         (full),
    .clearing     (clearing),
    .push         (push),
    .push_ent     (push_ent)
  );

  // decouple acceptance from execution
  mseu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ent  (push_ent),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  // execute, write back and present results
  mseu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .clearing     (clearing),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire
